### hw/rtl/cfb_pkg.sv
// ----------------------------------------------------------------------------
// cfb_pkg
// Shared types, constants and the frame length table of the frame builder.
// ----------------------------------------------------------------------------
package cfb_pkg;

    localparam int COMMAND_COUNT = 77;

    localparam logic [7:0] SYNC_BYTE     = 8'hAA;
    localparam logic [4:0] MIN_FRAME_LEN = 5'd6;

    // Result slot of the last header byte and of the checksum on a start item
    localparam logic [2:0] HDR_LAST_IDX = 3'd4;
    localparam logic [2:0] CSUM_IDX     = 3'd5;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PAYLOAD = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_UNDEF_LEN = 2'd1,
        ERR_NO_FRAME  = 2'd2,
        ERR_ABANDONED = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        t_err       error;
    } t_result;

    localparam logic [4:0] FRAME_LEN_ROM [0:COMMAND_COUNT-1] = '{
        5'd11, 5'd11, 5'd18, 5'd18, 5'd6,  5'd7,  5'd7,  5'd8,  5'd8,  5'd7,
        5'd7,  5'd6,  5'd20, 5'd20, 5'd6,  5'd20, 5'd20, 5'd7,
        5'd8,  5'd7,  5'd8,  5'd7,  5'd8,  5'd7,  5'd11, 5'd7,  5'd11, 5'd7,
        5'd11, 5'd7,  5'd10, 5'd6,  5'd10, 5'd6,  5'd10, 5'd6,  5'd8,  5'd19,
        5'd7,
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd6,
        5'd8,  5'd7,  5'd8,  5'd6,  5'd6,  5'd6,  5'd7,  5'd8,  5'd7,  5'd7,
        5'd10, 5'd6,  5'd6,  5'd8,  5'd6,  5'd7,  5'd7,  5'd6,
        5'd24, 5'd24, 5'd7,  5'd6,  5'd0,  5'd11, 5'd8,  5'd12, 5'd11, 5'd9,
        5'd7
    };

    // Total frame length of a command, 0 when the command is out of range
    function automatic logic [4:0] frame_len(input logic [6:0] cmd);
        logic [4:0] len;
        len = 5'd0;
        if ({1'b0, cmd} < 8'(COMMAND_COUNT)) begin
            len = FRAME_LEN_ROM[cmd];
        end
        return len;
    endfunction

endpackage

### hw/rtl/cfb_sequencer.sv
// ----------------------------------------------------------------------------
// cfb_sequencer
// Holds one input item and the open frame state, and steps through the
// results of the held item, one result per transfer to the output stage.
// ----------------------------------------------------------------------------
module cfb_sequencer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_operation,
    input  logic [6:0]        i_command,
    input  logic [7:0]        i_data_byte,
    input  logic [7:0]        i_device_address,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output cfb_pkg::t_result  o_res
);

    logic       r_busy;
    logic [2:0] r_idx;
    logic       r_open;
    logic [4:0] r_left;
    logic [7:0] r_xor;
    logic       r_op;
    logic [6:0] r_cmd;
    logic [7:0] r_data;

    logic       n_open;
    logic [4:0] n_left;
    logic [7:0] n_xor;
    logic       last;
    logic       fire;
    logic       accept;
    logic [4:0] len;
    logic       len_ok;
    logic [7:0] hdr_byte;
    cfb_pkg::t_result res;

    assign len    = cfb_pkg::frame_len(r_cmd);
    assign len_ok = (len >= cfb_pkg::MIN_FRAME_LEN);

    always_comb begin
        case (r_idx)
            3'd0:    hdr_byte = cfb_pkg::SYNC_BYTE;
            3'd1:    hdr_byte = i_device_address;
            3'd2:    hdr_byte = {3'b000, len};
            3'd3:    hdr_byte = {1'b0, r_cmd};
            default: hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        res.out_byte  = 8'h00;
        res.frame_end = 1'b1;
        res.error     = cfb_pkg::ERR_NONE;
        last          = 1'b1;
        n_open        = r_open;
        n_left        = r_left;
        n_xor         = r_xor;
        if (r_op == cfb_pkg::OP_START) begin
            if (r_open) begin
                res.error = cfb_pkg::ERR_ABANDONED;
                n_open    = 1'b0;
                n_left    = 5'd0;
                n_xor     = 8'h00;
            end else if (!len_ok) begin
                res.error = cfb_pkg::ERR_UNDEF_LEN;
            end else if (r_idx == cfb_pkg::CSUM_IDX) begin
                // zero-payload frame: checksum follows the header directly
                res.out_byte = r_xor;
                n_xor        = 8'h00;
            end else begin
                res.out_byte  = hdr_byte;
                res.frame_end = 1'b0;
                n_xor         = (r_idx == 3'd0) ? cfb_pkg::SYNC_BYTE : (r_xor ^ hdr_byte);
                if (r_idx == cfb_pkg::HDR_LAST_IDX) begin
                    n_left = 5'(len - cfb_pkg::MIN_FRAME_LEN);
                    if (len == cfb_pkg::MIN_FRAME_LEN) begin
                        last = 1'b0;
                    end else begin
                        n_open = 1'b1;
                    end
                end else begin
                    last = 1'b0;
                end
            end
        end else begin
            if (!r_open) begin
                res.error = cfb_pkg::ERR_NO_FRAME;
            end else if (r_idx != 3'd0) begin
                res.out_byte = r_xor;
                n_open       = 1'b0;
                n_left       = 5'd0;
                n_xor        = 8'h00;
            end else begin
                res.out_byte  = r_data;
                res.frame_end = 1'b0;
                n_xor         = r_xor ^ r_data;
                n_left        = 5'(r_left - 5'd1);
                last          = (r_left != 5'd1);
            end
        end
    end

    assign fire        = r_busy && i_res_ready;
    assign o_in_ready  = !r_busy || (fire && last);
    assign accept      = i_in_valid && o_in_ready;
    assign o_res_valid = r_busy;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
            r_open <= 1'b0;
            r_left <= 5'd0;
            r_xor  <= 8'h00;
        end else begin
            if (fire) begin
                r_open <= n_open;
                r_left <= n_left;
                r_xor  <= n_xor;
                r_idx  <= last ? 3'd0 : 3'(r_idx + 3'd1);
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (fire && last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_cmd  <= i_command;
            r_data <= i_data_byte;
        end
    end

    // the checksum slot of the last payload item runs with the count at zero
    a_open_has_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_open && r_idx == 3'd0) |-> (r_left != 5'd0))
        else $error("frame open with no payload left");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !r_open) |-> (r_xor == 8'h00 && r_left == 5'd0))
        else $error("closed frame left stale state");

    a_payload_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_op == cfb_pkg::OP_PAYLOAD) |-> (r_idx <= 3'd1))
        else $error("payload item stepped past its checksum");

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == 3'd0))
        else $error("result slot not rewound after item");

endmodule

### hw/rtl/cfb_out_reg.sv
// ----------------------------------------------------------------------------
// cfb_out_reg
// Output register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module cfb_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    output logic              o_res_ready,
    input  cfb_pkg::t_result  i_res,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_frame_end,
    output logic [1:0]        o_error
);

    logic             r_valid;
    cfb_pkg::t_result r_res;

    assign o_res_ready = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_res.out_byte;
    assign o_frame_end = r_res.frame_end;
    assign o_error     = r_res.error;

endmodule

### hw/rtl/command_frame_builder_unit.sv
// ----------------------------------------------------------------------------
// command_frame_builder_unit
// Path: items are registered in the sequencer, results in the output register.
// Throughput: one result per cycle unless i_out_ready stalls; an item holds the
// sequencer for its 1 to 6 results, so payload bytes stream at 1 per cycle.
// Reset (synchronous, active low) closes any open frame, empties both stages
// and clears the device address to 0.
// ----------------------------------------------------------------------------
module command_frame_builder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_device_address,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_operation,
    input  logic [6:0] i_command,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_frame_end,
    output logic [1:0] o_error
);

    logic [7:0]       r_device_address;
    logic             res_valid;
    logic             res_ready;
    cfb_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= 8'h00;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_device_address <= i_cfg_device_address;
        end
    end

    cfb_sequencer u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_command        (i_command),
        .i_data_byte      (i_data_byte),
        .i_device_address (r_device_address),
        .o_res_valid      (res_valid),
        .i_res_ready      (res_ready),
        .o_res            (res)
    );

    cfb_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_error     (o_error)
    );

endmodule
